// File: src/rmiqr_pkg.sv
// Shared types and constants for the outlier-rejected median filter.
package rmiqr_pkg;

	// Window length and derived sizes
	localparam int WINDOW  = 20;
	localparam int COUNT_W = $clog2(WINDOW + 1);
	localparam int IDX_W   = $clog2(WINDOW);
	localparam int Q1_IDX  = WINDOW / 4;
	localparam int Q3_IDX  = (3 * WINDOW) / 4;

	// Field and datapath widths
	localparam int SAMP_W   = 12;
	localparam int MED_W    = 13;
	localparam int KEEP_W   = 7;
	localparam int FACTOR_W = 10;
	localparam int IQR_W    = 13;
	localparam int PROD_W   = FACTOR_W + IQR_W;
	localparam int BND_W    = 26;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(179);

	// Per-cycle command to every cell of the sorting chain
	typedef struct packed {
		logic ins;
		logic rot;
	} cell_ctl_t;

	// Fixed cell taps around both quartile positions
	typedef struct packed {
		logic signed [SAMP_W-1:0] q1_lo;
		logic signed [SAMP_W-1:0] q1_hi;
		logic signed [SAMP_W-1:0] q3_lo;
		logic signed [SAMP_W-1:0] q3_hi;
	} quart_taps_t;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_QUART,
		ST_MUL,
		ST_BOUND,
		ST_SCAN1,
		ST_INDEX,
		ST_SCAN2,
		ST_EMIT
	} state_t;

endpackage

// File: src/rmiqr_cell.sv
// One cell of the insertion sorting chain; also rotates for scanning.
module rmiqr_cell import rmiqr_pkg::*; (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic signed [SAMP_W-1:0] sample,
	input  logic                     valid,
	input  logic signed [SAMP_W-1:0] prev_val,
	input  logic                     prev_shift,
	input  logic signed [SAMP_W-1:0] next_val,
	output logic signed [SAMP_W-1:0] val,
	output logic                     shift
);

	logic signed [SAMP_W-1:0] val_q;

	// Held entry moves right when it is larger than the new item
	assign shift = valid && (val_q > sample);
	assign val   = val_q;

	// Insert, rotate toward the head, or hold
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!valid || shift) begin
				val_q <= prev_shift ? prev_val : sample;
			end
		end else if (ctl.rot) begin
			val_q <= next_val;
		end
	end

endmodule

// File: src/rmiqr_ctrl.sv
// Sequencer: window count, quartiles, bounds, two scans and result register.
module rmiqr_ctrl import rmiqr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic        [FACTOR_W-1:0] factor,
	input  quart_taps_t                taps,
	input  logic signed [SAMP_W-1:0]   head,
	output cell_ctl_t                  ctl,
	output logic        [COUNT_W-1:0]  count,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [MED_W-1:0]    median_snr,
	output logic        [KEEP_W-1:0]   kept_count
);

	state_t state_q, state_d;

	logic        [COUNT_W-1:0] count_q;
	logic        [IDX_W-1:0]   idx_q;
	logic signed [MED_W-1:0]   q1d_q, q3d_q;
	logic        [PROD_W-1:0]  prod_q;
	logic signed [BND_W-1:0]   lo_q, hi_q;
	logic        [COUNT_W-1:0] below_q, above_q, k_q;
	logic        [IDX_W-1:0]   m1_q, m2_q;
	logic signed [SAMP_W-1:0]  med_a_q, med_b_q;
	logic                      out_valid_q;
	logic signed [MED_W-1:0]   median_q;
	logic        [KEEP_W-1:0]  kept_q;

	logic signed [MED_W-1:0]   q1d, q3d, iqr_full;
	logic signed [BND_W-1:0]   head_x, prod_x;
	logic        [COUNT_W-1:0] k_c, m1_sum, m2_sum;
	logic                      accept, last_idx, load_out;

	assign accept   = (state_q == ST_FILL) && in_valid;
	assign last_idx = (idx_q == IDX_W'(WINDOW - 1));

	// Doubled quartiles from the fixed taps
	always_comb begin
		if (WINDOW % 2 == 0) begin
			q1d = MED_W'(taps.q1_lo) + MED_W'(taps.q1_hi);
			q3d = MED_W'(taps.q3_lo) + MED_W'(taps.q3_hi);
		end else begin
			q1d = MED_W'(taps.q1_hi) <<< 1;
			q3d = MED_W'(taps.q3_hi) <<< 1;
		end
	end

	assign iqr_full = q3d_q - q1d_q;
	assign prod_x   = $signed({{(BND_W - PROD_W){1'b0}}, prod_q});
	assign head_x   = BND_W'(head) <<< 9;

	// Survivor count and the two median positions inside the kept range
	assign k_c    = COUNT_W'(WINDOW) - below_q - above_q;
	assign m1_sum = below_q + ((k_c - COUNT_W'(1)) >> 1);
	assign m2_sum = below_q + (k_c >> 1);

	// Outputs of the sequencer
	always_comb begin
		in_stall = (state_q != ST_FILL);
		ctl.ins  = accept;
		ctl.rot  = (state_q == ST_SCAN1) || (state_q == ST_SCAN2);
		load_out = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (accept && (count_q == COUNT_W'(WINDOW - 1))) begin
					state_d = ST_QUART;
				end
			end
			ST_QUART: state_d = ST_MUL;
			ST_MUL:   state_d = ST_BOUND;
			ST_BOUND: state_d = ST_SCAN1;
			ST_SCAN1: begin
				if (last_idx) begin
					state_d = ST_INDEX;
				end
			end
			ST_INDEX: state_d = ST_SCAN2;
			ST_SCAN2: begin
				if (last_idx) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (load_out) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= (count_q == COUNT_W'(WINDOW - 1)) ? '0 : count_q + COUNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_QUART: begin
				q1d_q <= q1d;
				q3d_q <= q3d;
			end
			ST_MUL: begin
				prod_q <= PROD_W'(factor) * PROD_W'(iqr_full[IQR_W-1:0]);
			end
			ST_BOUND: begin
				lo_q    <= (BND_W'(q1d_q) <<< 8) - prod_x;
				hi_q    <= (BND_W'(q3d_q) <<< 8) + prod_x;
				below_q <= '0;
				above_q <= '0;
				idx_q   <= '0;
			end
			ST_SCAN1: begin
				if (head_x < lo_q) begin
					below_q <= below_q + COUNT_W'(1);
				end
				if (head_x > hi_q) begin
					above_q <= above_q + COUNT_W'(1);
				end
				idx_q <= idx_q + IDX_W'(1);
			end
			ST_INDEX: begin
				k_q   <= k_c;
				m1_q  <= m1_sum[IDX_W-1:0];
				m2_q  <= m2_sum[IDX_W-1:0];
				idx_q <= '0;
			end
			ST_SCAN2: begin
				if (idx_q == m1_q) begin
					med_a_q <= head;
				end
				if (idx_q == m2_q) begin
					med_b_q <= head;
				end
				idx_q <= idx_q + IDX_W'(1);
			end
			ST_EMIT: begin
				if (load_out) begin
					median_q <= MED_W'(med_a_q) + MED_W'(med_b_q);
					kept_q   <= KEEP_W'(k_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign count      = count_q;
	assign out_valid  = out_valid_q;
	assign median_snr = median_q;
	assign kept_count = kept_q;

endmodule

// File: src/robust_median_iqr_filter.sv
// WINDOW items, one per cycle while the input is not stalled, fill the sorting chain
// of cells. After the last item the input stalls through the steps: quartiles, one
// multiply, bounds, a full rotation of the chain past its head cell, the median
// indices, a second full rotation, then the result register. The input reopens in
// the same cycle that the result is shown. Reset clears the window count, sequencer and
// output valid, and sets the factor register to 179; the chain itself needs no clearing.
module robust_median_iqr_filter import rmiqr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic        [FACTOR_W-1:0] outlier_factor,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMP_W-1:0]   snr_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [MED_W-1:0]    median_snr,
	output logic        [KEEP_W-1:0]   kept_count
);

	logic        [FACTOR_W-1:0] factor_q;
	cell_ctl_t                  ctl;
	logic        [COUNT_W-1:0]  count;
	quart_taps_t                taps;
	logic signed [SAMP_W-1:0]   cell_val   [WINDOW];
	logic                       cell_shift [WINDOW];

	// Configuration register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
		end else if (cfg_valid) begin
			factor_q <= outlier_factor;
		end
	end

	// Sorting chain: each cell sees its left and right neighbor
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		logic signed [SAMP_W-1:0] prev_val;
		logic                     prev_shift;
		if (i == 0) begin : g_first
			assign prev_val   = '0;
			assign prev_shift = 1'b0;
		end else begin : g_rest
			assign prev_val   = cell_val[i-1];
			assign prev_shift = cell_shift[i-1];
		end
		rmiqr_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.sample     (snr_sample),
			.valid      (COUNT_W'(i) < count),
			.prev_val   (prev_val),
			.prev_shift (prev_shift),
			.next_val   (cell_val[(i + 1) % WINDOW]),
			.val        (cell_val[i]),
			.shift      (cell_shift[i])
		);
	end

	// Fixed taps around the quartile positions
	assign taps.q1_lo = cell_val[Q1_IDX - 1];
	assign taps.q1_hi = cell_val[Q1_IDX];
	assign taps.q3_lo = cell_val[Q3_IDX - 1];
	assign taps.q3_hi = cell_val[Q3_IDX];

	rmiqr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.factor     (factor_q),
		.taps       (taps),
		.head       (cell_val[0]),
		.ctl        (ctl),
		.count      (count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.median_snr (median_snr),
		.kept_count (kept_count)
	);

endmodule

// File: src/rmiqr_chk.sv
// Port-level checker for the outlier-rejected median filter, bound to the top.
module rmiqr_chk import rmiqr_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic        [FACTOR_W-1:0] outlier_factor,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic signed [SAMP_W-1:0]   snr_sample,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [MED_W-1:0]    median_snr,
	input logic        [KEEP_W-1:0]   kept_count
);

	// Hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(median_snr) && $stable(kept_count))
		else $error("stalled result item changed");

	// Keep at least one and at most a window of samples
	a_kept_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kept_count != '0) && (kept_count <= KEEP_W'(WINDOW)))
		else $error("kept_count out of range");

	// Produce a result only at the end of a stalled processing phase
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result item appeared while input was open");

	// Close the input only right after an accepted item
	a_stall_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stalled without a completing item");

endmodule

bind robust_median_iqr_filter rmiqr_chk u_chk (.*);
